### rtl/core/qcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qcc_pkg;

   localparam int unsigned POS_W    = 12;
   localparam int unsigned MOD_W    = 13;
   localparam int unsigned TALLY_W  = 16;
   localparam int unsigned STEP_W   = 2;
   localparam int unsigned LOAD_W   = 12;
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned CSR_IDX_W = 4;

   localparam logic [MOD_W-1:0] MODULUS_MIN   = 13'd2;
   localparam logic [MOD_W-1:0] MODULUS_MAX   = 13'd4096;
   localparam logic [MOD_W-1:0] MODULUS_RESET = 13'd100;

   localparam logic signed [TALLY_W-1:0] TALLY_MAX = 16'sh7FFF;
   localparam logic signed [TALLY_W-1:0] TALLY_MIN = 16'sh8000;

   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_MODULUS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_DIRECTION = 4'd1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_TAKE   = 2'd1,
      FUNC_LOAD   = 2'd2
   } func_type;

   typedef logic signed [STEP_W-1:0] step_type;

   typedef struct packed {
      logic [POS_W-1:0]          position;
      logic signed [TALLY_W-1:0] tally;
   } counter_type;

   // index is {previous A, previous B, current A, current B}
   localparam step_type STEP_TABLE [16] = '{
       2'sd0,  2'sd1, -2'sd1,  2'sd0,
      -2'sd1,  2'sd0,  2'sd0,  2'sd1,
       2'sd1,  2'sd0,  2'sd0, -2'sd1,
       2'sd0, -2'sd1,  2'sd1,  2'sd0
   };

endpackage

`default_nettype wire

### rtl/core/qcc_step_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module qcc_step_decode (
   input  wire logic [1:0]       last_ab,
   input  wire logic [1:0]       now_ab,
   input  wire logic             invert,
   output qcc_pkg::step_type     step
);

   qcc_pkg::step_type raw_step;

   always_comb begin
      raw_step = qcc_pkg::STEP_TABLE[{last_ab, now_ab}];
      step     = invert ? -raw_step : raw_step;
   end

endmodule

`default_nettype wire

### rtl/core/qcc_click_update.sv
`timescale 1ns / 1ps
`default_nettype none

module qcc_click_update #(
   parameter int unsigned PULSES_PER_CLICK = 4,
   parameter int unsigned RES_W            = 5
) (
   input  wire logic [qcc_pkg::FUNC_W-1:0]        func,
   input  wire qcc_pkg::step_type                 step,
   input  wire logic [qcc_pkg::LOAD_W-1:0]        load_value,
   input  wire logic [qcc_pkg::MOD_W-1:0]         modulus,
   input  wire logic signed [RES_W-1:0]           residue,
   input  wire qcc_pkg::counter_type              counter,
   output logic signed [RES_W-1:0]                residue_next,
   output qcc_pkg::counter_type                   counter_next,
   output logic signed [qcc_pkg::TALLY_W-1:0]     shown,
   output qcc_pkg::step_type                      shown_step,
   output logic                                   sample_taken
);

   localparam logic signed [RES_W-1:0] PPC = RES_W'(PULSES_PER_CLICK);

   logic [qcc_pkg::MOD_W-1:0] eff_mod;
   logic [qcc_pkg::MOD_W-1:0] mod_m1;
   logic [qcc_pkg::MOD_W-1:0] pos_ext;
   logic [qcc_pkg::MOD_W-1:0] pos_inc;
   logic signed [RES_W-1:0]   sum;
   logic                      move_up;
   logic                      move_down;

   always_comb begin
      if (modulus < qcc_pkg::MODULUS_MIN) begin
         eff_mod = qcc_pkg::MODULUS_MIN;
      end else if (modulus > qcc_pkg::MODULUS_MAX) begin
         eff_mod = qcc_pkg::MODULUS_MAX;
      end else begin
         eff_mod = modulus;
      end
      mod_m1  = eff_mod - 13'd1;
      pos_ext = {1'b0, counter.position};
      pos_inc = pos_ext + 13'd1;

      sum          = residue + RES_W'(step);
      move_up      = 1'b0;
      move_down    = 1'b0;
      residue_next = residue;
      counter_next = counter;
      shown        = counter.tally;
      shown_step   = '0;
      sample_taken = 1'b0;

      unique case (func)
         qcc_pkg::FUNC_SAMPLE: begin
            sample_taken = 1'b1;
            shown_step   = step;
            if (step != '0) begin
               if (sum >= PPC) begin
                  residue_next = sum - PPC;
                  move_up      = 1'b1;
               end else if (sum <= -PPC) begin
                  residue_next = sum + PPC;
                  move_down    = 1'b1;
               end else begin
                  residue_next = sum;
               end
            end
            if (move_up) begin
               counter_next.position = (pos_inc >= eff_mod) ? '0
                                                            : pos_inc[qcc_pkg::POS_W-1:0];
               if (counter.tally != qcc_pkg::TALLY_MAX) begin
                  counter_next.tally = counter.tally + 16'sd1;
               end
            end else if (move_down) begin
               counter_next.position = (pos_ext == '0 || pos_ext >= eff_mod)
                                       ? mod_m1[qcc_pkg::POS_W-1:0]
                                       : counter.position - 12'd1;
               if (counter.tally != qcc_pkg::TALLY_MIN) begin
                  counter_next.tally = counter.tally - 16'sd1;
               end
            end
            shown = counter_next.tally;
         end
         qcc_pkg::FUNC_TAKE: begin
            counter_next.tally = '0;
         end
         qcc_pkg::FUNC_LOAD: begin
            counter_next.position = ({1'b0, load_value} > mod_m1)
                                    ? mod_m1[qcc_pkg::POS_W-1:0] : load_value;
            counter_next.tally    = '0;
            residue_next          = '0;
            shown                 = '0;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/quadrature_click_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tdata {load_value, pin_b, pin_a}, tuser func
// rsp      out  rsp_tvalid/tready     tdata {step, clicks, position}
// csr      in   csr_valid/ready       csr_index, csr_data
//
// One request per cycle sustained while rsp_tready stays high; each request gives one response,
// through an input register and a result register.
// Decode and counter update are combinational between those two registers.
// Reset clears position, tally, residue and last pins; modulus 100, inversion on.
// A stalled response holds the result register, and the input register behind it.

module quadrature_click_counter #(
   parameter int unsigned PULSES_PER_CLICK = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // pin_a, pin_b, load_value[11:0], zero fill
   input  wire logic [1:0]  req_tuser,   // func[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // position[11:0], clicks[15:0], step[1:0], zero fill
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [qcc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [qcc_pkg::MOD_W-1:0]     csr_data
);

   localparam int unsigned RES_W = $clog2(PULSES_PER_CLICK + 1) + 2;

   logic [qcc_pkg::MOD_W-1:0] modulus_ff, modulus_in;
   logic                      invert_ff, invert_in;

   logic                          in_valid_ff, in_valid_in;
   logic [qcc_pkg::FUNC_W-1:0]    in_func_ff, in_func_in;
   logic [1:0]                    in_ab_ff, in_ab_in;
   logic [qcc_pkg::LOAD_W-1:0]    in_load_ff, in_load_in;

   logic [1:0]              last_ab_ff, last_ab_in;
   logic signed [RES_W-1:0] residue_ff, residue_in;
   qcc_pkg::counter_type    counter_ff, counter_in;

   logic                              out_valid_ff, out_valid_in;
   logic [qcc_pkg::POS_W-1:0]         out_pos_ff, out_pos_in;
   logic signed [qcc_pkg::TALLY_W-1:0] out_clicks_ff, out_clicks_in;
   qcc_pkg::step_type                 out_step_ff, out_step_in;

   logic                               advance;
   logic                               take_req;
   qcc_pkg::step_type                  step;
   qcc_pkg::step_type                  shown_step;
   logic signed [RES_W-1:0]            residue_next;
   qcc_pkg::counter_type               counter_next;
   logic signed [qcc_pkg::TALLY_W-1:0] shown;
   logic                               sample_taken;

   qcc_step_decode u_decode (
      .last_ab (last_ab_ff),
      .now_ab  (in_ab_ff),
      .invert  (invert_ff),
      .step    (step)
   );

   qcc_click_update #(
      .PULSES_PER_CLICK (PULSES_PER_CLICK),
      .RES_W            (RES_W)
   ) u_update (
      .func         (in_func_ff),
      .step         (step),
      .load_value   (in_load_ff),
      .modulus      (modulus_ff),
      .residue      (residue_ff),
      .counter      (counter_ff),
      .residue_next (residue_next),
      .counter_next (counter_next),
      .shown        (shown),
      .shown_step   (shown_step),
      .sample_taken (sample_taken)
   );

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take_req   = req_tvalid && req_tready;

   always_comb begin
      modulus_in = modulus_ff;
      invert_in  = invert_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == qcc_pkg::CSR_POSITION_MODULUS) begin
            modulus_in = csr_data;
         end else if (csr_index == qcc_pkg::CSR_INVERT_DIRECTION) begin
            invert_in = csr_data[0];
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_func_in  = in_func_ff;
      in_ab_in    = in_ab_ff;
      in_load_in  = in_load_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
         in_func_in  = req_tuser;
         in_ab_in    = {req_tdata[0], req_tdata[1]};
         in_load_in  = req_tdata[13:2];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      last_ab_in    = last_ab_ff;
      residue_in    = residue_ff;
      counter_in    = counter_ff;
      out_valid_in  = out_valid_ff;
      out_pos_in    = out_pos_ff;
      out_clicks_in = out_clicks_ff;
      out_step_in   = out_step_ff;
      if (advance) begin
         if (sample_taken) begin
            last_ab_in = in_ab_ff;
         end
         residue_in    = residue_next;
         counter_in    = counter_next;
         out_valid_in  = 1'b1;
         out_pos_in    = counter_next.position;
         out_clicks_in = shown;
         out_step_in   = shown_step;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= qcc_pkg::MODULUS_RESET;
         invert_ff    <= 1'b1;
         in_valid_ff  <= 1'b0;
         last_ab_ff   <= '0;
         residue_ff   <= '0;
         counter_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         invert_ff    <= invert_in;
         in_valid_ff  <= in_valid_in;
         last_ab_ff   <= last_ab_in;
         residue_ff   <= residue_in;
         counter_ff   <= counter_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_func_ff    <= in_func_in;
      in_ab_ff      <= in_ab_in;
      in_load_ff    <= in_load_in;
      out_pos_ff    <= out_pos_in;
      out_clicks_ff <= out_clicks_in;
      out_step_ff   <= out_step_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_step_ff, out_clicks_ff, out_pos_ff};

endmodule

`default_nettype wire
